// ===== rtl/zwp_pkg.sv =====
`timescale 1ns / 1ps
// zwp_pkg: constants, codes and the zone entry type of the zone write pointer tracker
// no dependencies
package zwp_pkg;

  localparam int ZONES        = 1024;
  localparam int ZONE_W       = 10;
  localparam int OPEN_SLOTS   = 128;
  localparam int SLOT_W       = 7;
  localparam int OCNT_W       = 8;
  localparam int SECTOR_SHIFT = 9;
  localparam int WP_W         = 40;
  localparam int OFF_W        = 48;
  localparam int SIZE_W       = 25;
  localparam int COUNT_W      = 11;
  localparam int DIVISOR_W    = SIZE_W + SECTOR_SHIFT;
  localparam int MIN_BIG_REQ  = 4096;
  localparam int MIN_ADVANCE  = 8;
  localparam int DEF_OPEN     = 128;
  localparam int MAX_SIZE     = 16777216;

  localparam logic [1:0] ACT_INIT = 2'd0;
  localparam logic [1:0] ACT_SEQ  = 2'd1;
  localparam logic [1:0] ACT_RAND = 2'd2;
  localparam logic [1:0] ACT_DONE = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_RETRY   = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_NOTOPEN = 2'd3;

  localparam logic [1:0] REG_ZONE_SIZE  = 2'd0;
  localparam logic [1:0] REG_ZONE_COUNT = 2'd1;
  localparam logic [1:0] REG_MAX_OPEN   = 2'd2;

  typedef struct packed {
    logic [WP_W-1:0]   wp;
    logic signed [7:0] pend;
    logic              is_open;
    logic [SLOT_W-1:0] slot;
  } zone_entry_t;

endpackage

// ===== rtl/zone_write_pointer_tracker.sv =====
`timescale 1ns / 1ps
// zone_write_pointer_tracker: per-zone write pointers, pending counts and open zone list
// depends on zwp_pkg
// one item at a time; the next item is taken in the idle state that follows,
// once the result register is free
// init: writes all ZONES zone entries (one zone memory write per cycle)
// sequential pick: 48-step divider, then a zone read and compare per zone visited
// random pick: same divider, then a zone read; completion: no divider
// reset clears control and sets config to defaults; zone store contents undefined until an init item
module zone_write_pointer_tracker
  import zwp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          action,
  input  logic [OFF_W-1:0]    byte_offset,
  input  logic [ZONE_W-1:0]   zone_id,
  input  logic [23:0]         request_bytes,
  input  logic [31:0]         random_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [OFF_W-1:0]    result_offset,
  output logic [ZONE_W-1:0]   result_zone,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [SIZE_W-1:0]   cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_DIV, S_DIV_END,
    S_SEQ_W, S_SEQ_C, S_LAST_W, S_LAST_C,
    S_RND_OW, S_RND_OC, S_RND_W, S_RND_C,
    S_DONE_W, S_DONE_C, S_NXT_W, S_NXT_C,
    S_REM_OW, S_REM_OC, S_MOV_W, S_MOV_C, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [SIZE_W-1:0]  zone_size;
  logic [COUNT_W-1:0] zone_count;
  logic [7:0]         max_open;

  // saturated working values of the registers
  logic [SIZE_W-1:0]  eff_size;
  logic [COUNT_W-1:0] eff_count;
  logic [OCNT_W-1:0]  eff_open;
  logic [7:0]         open_req;

  always_comb begin
    if (zone_size == '0) eff_size = SIZE_W'(1);
    else if (zone_size > SIZE_W'(MAX_SIZE)) eff_size = SIZE_W'(MAX_SIZE);
    else eff_size = zone_size;
    if (zone_count == '0) eff_count = COUNT_W'(1);
    else if (zone_count > COUNT_W'(ZONES)) eff_count = COUNT_W'(ZONES);
    else eff_count = zone_count;
    open_req = (max_open == '0) ? 8'(DEF_OPEN) : max_open;
    eff_open = (open_req > 8'(OPEN_SLOTS)) ? OCNT_W'(OPEN_SLOTS) : OCNT_W'(open_req);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_size  <= SIZE_W'(524288);
      zone_count <= COUNT_W'(1024);
      max_open   <= 8'd128;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ZONE_SIZE:  zone_size  <= cfg_data;
        REG_ZONE_COUNT: zone_count <= cfg_data[COUNT_W-1:0];
        REG_MAX_OPEN:   max_open   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // zone memory: write pointer, pending count, open flag and list slot per zone
  zone_entry_t zmem [ZONES];
  zone_entry_t zrdata;
  logic [ZONE_W-1:0] zaddr;
  logic              zwe;
  logic [ZONE_W-1:0] zwa;
  zone_entry_t       zwd;

  // open zone list memory
  logic [ZONE_W-1:0] omem [OPEN_SLOTS];
  logic [ZONE_W-1:0] ordata;
  logic [SLOT_W-1:0] oaddr;
  logic              owe;
  logic [SLOT_W-1:0] owa;
  logic [ZONE_W-1:0] owd;

  always_ff @(posedge clk) begin
    if (zwe) zmem[zwa] <= zwd;
    zrdata <= zmem[zaddr];
  end

  always_ff @(posedge clk) begin
    if (owe) omem[owa] <= owd;
    ordata <= omem[oaddr];
  end

  // item registers
  logic [1:0]          act;
  logic [23:0]         req;
  logic [ZONE_W-1:0]   last_zone;
  logic [OCNT_W-1:0]   open_count;
  logic                rnd_full;
  logic [ZONE_W-1:0]   cur_zone;
  logic [ZONE_W-1:0]   icnt;
  logic [WP_W-1:0]     acc;
  logic [DIVISOR_W:0]  zend;
  logic                was_open;
  logic [SLOT_W-1:0]   kslot;
  logic [WP_W:0]       tmp_r;

  // divider
  logic [OFF_W-1:0]     dvd;
  logic [OFF_W-1:0]     quo;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [5:0]           dcnt;
  logic [DIVISOR_W:0]   dtry;
  logic                 dge;

  assign dtry = {rem, dvd[OFF_W-1]};
  assign dge  = dtry >= {1'b0, dvs};

  // result staging
  logic [1:0]        res_st;
  logic [OFF_W-1:0]  res_off;
  logic [ZONE_W-1:0] res_zone;

  // pick bookkeeping: bump pending with saturation, optionally join the open list
  function automatic zone_entry_t take_entry(zone_entry_t e, logic join_list,
                                             logic [SLOT_W-1:0] s);
    zone_entry_t r;
    r = e;
    if (e.pend < 8'sd127) r.pend = e.pend + 8'sd1;
    if (join_list) begin
      r.is_open = 1'b1;
      r.slot    = s;
    end
    return r;
  endfunction

  function automatic logic [OFF_W-1:0] to_bytes(logic [WP_W:0] wp);
    return OFF_W'({wp, {SECTOR_SHIFT{1'b0}}});
  endfunction

  // completion arithmetic
  logic [WP_W:0] tmp;
  logic [15:0]   adv;
  assign adv = (req < 24'(MIN_BIG_REQ)) ? 16'(MIN_ADVANCE)
                                          : 16'(req >> SECTOR_SHIFT);
  assign tmp = {1'b0, zrdata.wp} + (WP_W+1)'(adv);

  // conditions checked in the compare states
  logic seq_take, seq_join, rnd_join, rnd_take, done_fits;
  logic [COUNT_W-1:0] next_zone;
  assign next_zone = COUNT_W'(zaddr) + COUNT_W'(1);
  assign seq_take  = zrdata.is_open && (zrdata.pend >= 8'sd0);
  assign seq_join  = !zrdata.is_open && (open_count < eff_open);
  assign rnd_join  = !rnd_full && !zrdata.is_open && (zrdata.pend == 8'sd0);
  assign rnd_take  = rnd_full && (zrdata.pend == 8'sd0);
  assign done_fits = tmp < (WP_W+1)'(zend);

  // memory write requests
  always_comb begin
    zwe = 1'b0;
    zwa = zaddr;
    zwd = zrdata;
    owe = 1'b0;
    owa = open_count[SLOT_W-1:0];
    owd = zaddr;
    case (state)
      S_INIT: begin
        zwe         = 1'b1;
        zwa         = icnt;
        zwd.wp      = ({1'b0, icnt} < eff_count) ? acc : '0;
        zwd.pend    = '0;
        zwd.is_open = 1'b0;
        zwd.slot    = '0;
      end
      S_SEQ_C: begin
        zwe = seq_take || seq_join;
        zwd = take_entry(zrdata, seq_join, open_count[SLOT_W-1:0]);
        owe = seq_join;
      end
      S_LAST_C: begin
        zwe = 1'b1;
        zwd = take_entry(zrdata, 1'b0, '0);
      end
      S_RND_C: begin
        zwe = rnd_join || rnd_take;
        zwd = take_entry(zrdata, rnd_join, open_count[SLOT_W-1:0]);
        owe = rnd_join;
      end
      S_DONE_C: begin
        zwe = 1'b1;
        if (done_fits) begin
          zwd.wp = tmp[WP_W-1:0];
          if (zrdata.pend > 8'sd0) zwd.pend = zrdata.pend - 8'sd1;
        end else begin
          zwd.wp      = WP_W'(zend);
          zwd.pend    = -8'sd1;
          zwd.is_open = 1'b0;
        end
      end
      S_NXT_C: begin
        // overflow spills into the next zone, only when one was read
        zwe    = (zaddr != cur_zone);
        zwd.wp = tmp_r[WP_W-1:0];
      end
      S_REM_OC: begin
        // last list entry moves into the freed slot
        owe = 1'b1;
        owa = kslot;
        owd = ordata;
      end
      S_MOV_C: begin
        zwe      = 1'b1;
        zwd.slot = kslot;
      end
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      open_count <= '0;
      last_zone  <= '0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act      <= action;
            req      <= request_bytes;
            cur_zone <= zone_id;
            zaddr    <= zone_id;
            icnt     <= '0;
            acc      <= '0;
            rem      <= '0;
            quo      <= '0;
            dcnt     <= '0;
            rnd_full <= !(open_count < eff_open);
            unique case (action)
              ACT_INIT: state <= S_INIT;
              ACT_SEQ: begin
                dvd   <= byte_offset;
                dvs   <= {eff_size, {SECTOR_SHIFT{1'b0}}};
                state <= S_DIV;
              end
              ACT_RAND: begin
                dvd   <= OFF_W'(random_value);
                dvs   <= (open_count < eff_open) ? DIVISOR_W'(eff_count)
                                                 : DIVISOR_W'(open_count);
                state <= S_DIV;
              end
              ACT_DONE: begin
                // out-of-range zone leaves with the default range status
                if ({1'b0, zone_id} >= eff_count) begin
                  state <= S_OUT;
                end else begin
                  state <= S_DONE_W;
                end
              end
              default: ;
            endcase
            res_off  <= '0;
            res_zone <= '0;
            res_st   <= ST_RANGE;
          end
        end
        S_INIT: begin
          icnt <= icnt + ZONE_W'(1);
          acc  <= acc + WP_W'(eff_size);
          if (icnt == ZONE_W'(ZONES - 1)) begin
            open_count <= '0;
            res_st     <= ST_DONE;
            state      <= S_OUT;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          dvd  <= {dvd[OFF_W-2:0], 1'b0};
          quo  <= {quo[OFF_W-2:0], dge};
          rem  <= dge ? DIVISOR_W'(dtry - {1'b0, dvs}) : DIVISOR_W'(dtry);
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'(OFF_W - 1)) state <= S_DIV_END;
        end
        S_DIV_END: begin
          if (act == ACT_SEQ) begin
            if (quo >= OFF_W'(eff_count)) begin
              res_st <= ST_RANGE;
              state  <= S_OUT;
            end else begin
              zaddr <= quo[ZONE_W-1:0];
              state <= S_SEQ_W;
            end
          end else if (!rnd_full) begin
            zaddr     <= rem[ZONE_W-1:0];
            last_zone <= rem[ZONE_W-1:0];
            state     <= S_RND_W;
          end else begin
            oaddr <= rem[SLOT_W-1:0];
            state <= S_RND_OW;
          end
        end
        S_SEQ_W: state <= S_SEQ_C;
        S_SEQ_C: begin
          if (seq_take || seq_join) begin
            if (seq_join) open_count <= open_count + OCNT_W'(1);
            last_zone <= zaddr;
            res_st    <= ST_DONE;
            res_off   <= to_bytes({1'b0, zrdata.wp});
            res_zone  <= zaddr;
            state     <= S_OUT;
          end else if (zrdata.is_open) begin
            // full zone: walk to the next one
            if (next_zone >= eff_count) begin
              res_st <= ST_RANGE;
              state  <= S_OUT;
            end else begin
              zaddr <= next_zone[ZONE_W-1:0];
              state <= S_SEQ_W;
            end
          end else if ({1'b0, last_zone} >= eff_count) begin
            res_st <= ST_RANGE;
            state  <= S_OUT;
          end else begin
            zaddr <= last_zone;
            state <= S_LAST_W;
          end
        end
        S_LAST_W: state <= S_LAST_C;
        S_LAST_C: begin
          res_st   <= ST_DONE;
          res_off  <= to_bytes({1'b0, zrdata.wp});
          res_zone <= zaddr;
          state    <= S_OUT;
        end
        S_RND_OW: state <= S_RND_OC;
        S_RND_OC: begin
          last_zone <= ordata;
          if ({1'b0, ordata} < eff_count) begin
            zaddr <= ordata;
            state <= S_RND_W;
          end else begin
            res_st <= ST_RETRY;
            state  <= S_OUT;
          end
        end
        S_RND_W: state <= S_RND_C;
        S_RND_C: begin
          if (rnd_join || rnd_take) begin
            if (rnd_join) open_count <= open_count + OCNT_W'(1);
            res_st   <= ST_DONE;
            res_off  <= to_bytes({1'b0, zrdata.wp});
            res_zone <= zaddr;
          end else begin
            res_st <= ST_RETRY;
          end
          state <= S_OUT;
        end
        S_DONE_W: begin
          zend  <= (DIVISOR_W+1)'(cur_zone * eff_size) + (DIVISOR_W+1)'(eff_size);
          state <= S_DONE_C;
        end
        S_DONE_C: begin
          res_zone <= cur_zone;
          was_open <= zrdata.is_open;
          kslot    <= zrdata.slot;
          tmp_r    <= tmp;
          if (done_fits) begin
            res_st  <= ST_DONE;
            res_off <= to_bytes(tmp);
            state   <= S_OUT;
          end else begin
            res_off <= to_bytes((WP_W+1)'(zend));
            if (tmp > (WP_W+1)'(zend) && next_zone < eff_count) begin
              zaddr <= next_zone[ZONE_W-1:0];
              state <= S_NXT_W;
            end else begin
              state <= S_NXT_C;
            end
          end
        end
        S_NXT_W: state <= S_NXT_C;
        S_NXT_C: begin
          // reached also without a spill; zaddr then still points at the filled
          // zone and no zone write is made here
          if (!was_open) begin
            res_st <= ST_NOTOPEN;
            state  <= S_OUT;
          end else if ({1'b0, kslot} != open_count - OCNT_W'(1)) begin
            oaddr <= SLOT_W'(open_count - OCNT_W'(1));
            state <= S_REM_OW;
          end else begin
            open_count <= open_count - OCNT_W'(1);
            res_st     <= ST_DONE;
            state      <= S_OUT;
          end
        end
        S_REM_OW: state <= S_REM_OC;
        S_REM_OC: begin
          zaddr <= ordata;
          state <= S_MOV_W;
        end
        S_MOV_W: state <= S_MOV_C;
        S_MOV_C: begin
          open_count <= open_count - OCNT_W'(1);
          res_st     <= ST_DONE;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            status        <= res_st;
            result_offset <= res_off;
            result_zone   <= res_zone;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
